// File: hdl/kmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_pkg: shared constants and types for the KMP stream matcher
// Sizes of the pattern stores, the input opcodes, the controller-to-datapath
// command set and the datapath status bundle.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int MAX_PATTERN  = 64;
  localparam int OFFSET_WIDTH = 32;

  // pattern length counts 0..MAX_PATTERN, store addresses 0..MAX_PATTERN-1
  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int PADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // input transaction opcodes
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_TEXT    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_RESTART,
    CMD_TEXT_START,
    CMD_TEXT_HIT,
    CMD_TEXT_FOLLOW,
    CMD_TEXT_MISS,
    CMD_APP_FIRST,
    CMD_APP_START,
    CMD_APP_HIT,
    CMD_APP_FOLLOW,
    CMD_APP_END
  } dp_cmd_t;

  typedef struct packed {
    logic hit;           // fetched pattern byte equals the held input byte
    logic text_last;     // the compared position is the last pattern byte
    logic fail_restart;  // fetched failure entry is the restart mark
    logic cur_zero;      // compared position is zero
    logic len_zero;      // pattern is empty
    logic len_full;      // pattern holds MAX_PATTERN bytes
    logic out_busy;      // result register holds a transaction not taken
  } dp_status_t;

endpackage
`default_nettype wire

// File: hdl/kmp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_datapath: pattern and failure stores, search registers, result register
// Executes one command per cycle from the controller and reports the
// compare results of the previous store read.
// ----------------------------------------------------------------------------
module kmp_datapath (
  input  wire                 clk,
  input  wire                 rst,
  input  var kmp_pkg::dp_cmd_t cmd,
  input  wire logic [7:0]     byte_value,
  input  wire                 out_ready,
  output kmp_pkg::dp_status_t status,
  output logic                out_valid,
  output logic [31:0]         match_start
);
  import kmp_pkg::*;

  typedef struct packed {
    logic               restart;
    logic [PADDR_W-1:0] idx;
  } fail_entry_t;

  // pattern store and optimized failure table
  logic [7:0]  pat_mem  [MAX_PATTERN];
  fail_entry_t fail_mem [MAX_PATTERN];

  logic [7:0]        pat_q;
  fail_entry_t       fail_q;

  logic [LEN_W-1:0]        len;
  logic [PADDR_W-1:0]      cnd;
  logic [PADDR_W-1:0]      matched;
  logic [OFFSET_WIDTH-1:0] offset;
  logic                    first;
  logic [7:0]              byte_q;
  logic [PADDR_W-1:0]      cur_idx;

  logic               rd_en;
  logic [PADDR_W-1:0] rd_addr;
  logic               pat_we;
  logic [PADDR_W-1:0] pos_addr;
  logic               fail_we;
  logic [PADDR_W-1:0] fail_wa;
  fail_entry_t        fail_wd;
  logic               text_last;

  function automatic logic [PADDR_W-1:0] clamp_idx(input logic [PADDR_W-1:0] x,
                                                   input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] lim;
    lim = n - LEN_W'(1);
    if (LEN_W'(x) > lim) return PADDR_W'(lim);
    return x;
  endfunction

  assign pos_addr  = PADDR_W'(len);
  assign text_last = (LEN_W'(cur_idx) + LEN_W'(1)) == len;

  // select the store read address for the next compare
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnd;
    case (cmd)
      CMD_TEXT_START: begin
        rd_en   = 1'b1;
        rd_addr = clamp_idx(matched, len);
      end
      CMD_TEXT_FOLLOW: begin
        rd_en   = 1'b1;
        rd_addr = clamp_idx(fail_q.idx, len);
      end
      CMD_APP_START: begin
        rd_en   = 1'b1;
        rd_addr = cnd;
      end
      CMD_APP_FOLLOW: begin
        rd_en   = 1'b1;
        rd_addr = fail_q.idx;
      end
      default: ;
    endcase
  end

  // build the failure entry of the appended byte
  always_comb begin
    pat_we  = (cmd == CMD_APP_FIRST) || (cmd == CMD_APP_START);
    fail_we = 1'b0;
    fail_wa = pos_addr;
    fail_wd = '{restart: 1'b0, idx: cur_idx};
    case (cmd)
      CMD_APP_FIRST: begin
        fail_we = 1'b1;
        fail_wa = '0;
        fail_wd = '{restart: 1'b1, idx: '0};
      end
      CMD_APP_HIT: begin
        fail_we = first;
        fail_wd = fail_q;
      end
      CMD_APP_FOLLOW, CMD_APP_END: begin
        fail_we = first;
      end
      default: ;
    endcase
  end

  // stores with registered read
  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[pos_addr] <= byte_value;
    if (rd_en)  pat_q <= pat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    if (rd_en)   fail_q <= fail_mem[rd_addr];
  end

  // search and builder control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      cnd       <= '0;
      matched   <= '0;
      offset    <= '0;
      first     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop a taken result unless a new match replaces it
      if (out_valid && out_ready && !((cmd == CMD_TEXT_HIT) && text_last)) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        CMD_CLEAR: begin
          len     <= '0;
          cnd     <= '0;
          matched <= '0;
          offset  <= '0;
        end
        CMD_RESTART: begin
          matched <= '0;
          offset  <= '0;
        end
        CMD_TEXT_START: offset <= offset + OFFSET_WIDTH'(1);
        CMD_TEXT_HIT: begin
          if (text_last) begin
            matched   <= cnd;
            out_valid <= 1'b1;
          end else begin
            matched <= cur_idx + PADDR_W'(1);
          end
        end
        CMD_TEXT_FOLLOW: matched <= fail_q.idx;
        CMD_TEXT_MISS:   matched <= '0;
        CMD_APP_FIRST: begin
          cnd <= '0;
          len <= LEN_W'(1);
        end
        CMD_APP_START: first <= 1'b1;
        CMD_APP_HIT: begin
          cnd   <= cur_idx + PADDR_W'(1);
          len   <= len + LEN_W'(1);
          first <= 1'b0;
        end
        CMD_APP_FOLLOW: first <= 1'b0;
        CMD_APP_END: begin
          cnd   <= '0;
          len   <= len + LEN_W'(1);
          first <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers: held byte, compared position, result
  always_ff @(posedge clk) begin
    if ((cmd == CMD_TEXT_START) || (cmd == CMD_APP_START)) byte_q <= byte_value;
    if (rd_en) cur_idx <= rd_addr;
    if ((cmd == CMD_TEXT_HIT) && text_last) begin
      match_start <= 32'(offset - OFFSET_WIDTH'(len));
    end
  end

  // report compare results to the controller
  always_comb begin
    status.hit          = pat_q == byte_q;
    status.text_last    = text_last;
    status.fail_restart = fail_q.restart;
    status.cur_zero     = cur_idx == '0;
    status.len_zero     = len == '0;
    status.len_full     = len == LEN_W'(MAX_PATTERN);
    status.out_busy     = out_valid && !out_ready;
  end

endmodule
`default_nettype wire

// File: hdl/kmp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_ctrl: sequencer for the KMP stream matcher
// Accepts input transactions, walks the failure chain for text bytes and
// for pattern appends, and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module kmp_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     opcode,
  input  var kmp_pkg::dp_status_t status,
  output kmp_pkg::dp_cmd_t    cmd
);
  import kmp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEXT,
    ST_APPEND
  } state_t;

  state_t state, state_next;

  assign in_ready = state == ST_IDLE;

  // decode transactions and step the failure walks
  always_comb begin
    cmd        = CMD_NONE;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (opcode)
            OP_CLEAR:   cmd = CMD_CLEAR;
            OP_RESTART: cmd = CMD_RESTART;
            OP_TEXT: begin
              cmd = CMD_TEXT_START;
              if (!status.len_zero) state_next = ST_TEXT;
            end
            OP_APPEND: begin
              // drop the append when the pattern is full
              if (status.len_zero) begin
                cmd = CMD_APP_FIRST;
              end else if (!status.len_full) begin
                cmd        = CMD_APP_START;
                state_next = ST_APPEND;
              end
            end
            default: ;
          endcase
        end
      end
      ST_TEXT: begin
        if (status.hit) begin
          // hold a completed match until the result register is free
          if (!(status.text_last && status.out_busy)) begin
            cmd        = CMD_TEXT_HIT;
            state_next = ST_IDLE;
          end
        end else if (!status.fail_restart && !status.cur_zero) begin
          cmd = CMD_TEXT_FOLLOW;
        end else begin
          cmd        = CMD_TEXT_MISS;
          state_next = ST_IDLE;
        end
      end
      ST_APPEND: begin
        if (status.hit) begin
          cmd        = CMD_APP_HIT;
          state_next = ST_IDLE;
        end else if (status.fail_restart) begin
          cmd        = CMD_APP_END;
          state_next = ST_IDLE;
        end else begin
          cmd = CMD_APP_FOLLOW;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/kmp_stream_matcher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_stream_matcher_top: streaming Knuth-Morris-Pratt byte-string matcher
// Builds the optimized failure table as pattern bytes arrive and reports the
// start offset of every (overlapping) match in the text stream.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_ready  opcode, byte_value
//   result   out        out_valid / out_ready match_start
//
// Clear, restart, a text byte on an empty pattern, a dropped append and the
// first pattern byte finish in the idle state. A text byte walks the failure
// chain with one store read per step; an append reads once per step of the
// candidate walk. Both walks follow the chain through the single read port
// of the stores. Reset clears the control registers only; the stores need
// no clearing pass. A completed match waits in its compare cycle while the
// result register still holds a transaction that is not taken.
// ----------------------------------------------------------------------------
module kmp_stream_matcher_top (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  byte_value,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [31:0]      match_start
);
  import kmp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  kmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .status   (status),
    .cmd      (cmd)
  );

  kmp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .byte_value  (byte_value),
    .out_ready   (out_ready),
    .status      (status),
    .out_valid   (out_valid),
    .match_start (match_start)
  );

endmodule
`default_nettype wire

// File: bench/tb_kmp_stream_matcher_top.sv
// ----------------------------------------------------------------------------
// tb_kmp_stream_matcher_top: self-checking bench for the KMP stream matcher
// Drives opcode/byte transactions into the matcher, predicts each match
// start offset with a behavioral KMP matcher kept in lockstep with the
// accepted inputs, and checks every result transaction in order.
// ----------------------------------------------------------------------------
module tb_kmp_stream_matcher_top;
  import kmp_pkg::*;

  localparam int PAT_MAX = kmp_pkg::MAX_PATTERN;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic [1:0]  opcode     = OP_CLEAR;
  logic [7:0]  byte_value = 8'h00;
  logic        out_ready  = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire  [31:0] match_start;

  kmp_stream_matcher_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .byte_value (byte_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .match_start(match_start)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Matcher state mirrored from accepted transactions
  logic [7:0]  pat_mem [PAT_MAX];
  int          fail_mem [PAT_MAX + 1];
  int          pat_len   = 0;
  int          cand_idx  = 0;
  int          match_cnt = 0;
  logic [31:0] text_off  = '0;

  logic [31:0] exp_starts [$];
  logic [31:0] want_start;
  int          err_cnt    = 0;
  int          items_sent = 0;
  bit          no_idle    = 1'b0;

  function automatic int clamp_to(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the mirrored matcher by one transaction; return 1 on a match
  function automatic bit kmp_advance(logic [1:0] op, logic [7:0] b,
                                     output logic [31:0] start);
    int          pos;
    int          cnd;
    int          i;
    logic [31:0] here;
    bit          done;
    bit          found;
    found = 1'b0;
    start = '0;
    case (op)
      OP_CLEAR: begin
        pat_len   = 0;
        cand_idx  = 0;
        match_cnt = 0;
        text_off  = '0;
      end
      OP_APPEND: begin
        // drop appends once the pattern is full
        if (pat_len < PAT_MAX) begin
          pos = pat_len;
          cnd = cand_idx;
          pat_mem[pos] = b;
          if (pos == 0) begin
            fail_mem[0] = -1;
            cnd = 0;
          end else begin
            if (b == pat_mem[cnd]) begin
              fail_mem[pos] = fail_mem[cnd];
            end else begin
              fail_mem[pos] = cnd;
              cnd = fail_mem[cnd];
              while (cnd >= 0 && b != pat_mem[cnd]) cnd = fail_mem[cnd];
            end
            cnd++;
          end
          pat_len  = pos + 1;
          cand_idx = cnd;
          fail_mem[pat_len] = cnd;
        end
      end
      OP_TEXT: begin
        here     = text_off;
        text_off = text_off + 32'd1;
        if (pat_len > 0) begin
          done = 1'b0;
          while (!done) begin
            i = clamp_to(match_cnt, pat_len - 1);
            if (pat_mem[i] == b) begin
              i++;
              if (i == pat_len) begin
                start = here + 32'd1 - 32'(pat_len);
                found = 1'b1;
                i = clamp_to(fail_mem[i], pat_len - 1);
              end
              match_cnt = i;
              done = 1'b1;
            end else if (fail_mem[i] > -1 && i > 0) begin
              match_cnt = fail_mem[i];
            end else begin
              match_cnt = 0;
              done = 1'b1;
            end
          end
        end
      end
      default: begin
        match_cnt = 0;
        text_off  = '0;
      end
    endcase
    return found;
  endfunction

  // Send one input transaction and record its expected match, if any
  task automatic send_item(logic [1:0] op, logic [7:0] b);
    logic [31:0] st;
    if (!no_idle && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 33);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    byte_value <= b;
    do @(posedge clk); while (!in_ready);
    if (kmp_advance(op, b, st)) exp_starts = {exp_starts, st};
    items_sent++;
  endtask

  // Hold off the sender until all expected matches are out, then settle
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (exp_starts.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Check each result transaction against the oldest expected start
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (exp_starts.size() == 0) begin
        $error("match_start: expected none, got %0h", match_start);
        err_cnt++;
      end else begin
        want_start = exp_starts.pop_front();
        if (match_start !== want_start) begin
          $error("match_start: expected %0h, got %0h", want_start, match_start);
          err_cnt++;
        end
      end
    end
    out_ready <= no_idle || ($urandom_range(99) >= 33);
  end

  // Text bytes with no pattern only advance the offset
  task automatic test_empty_pattern();
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_CLEAR, 8'hFF);
    send_item(OP_TEXT, 8'h5A);
  endtask

  // Extreme bytes, overlap, append mid-search and restart
  task automatic test_directed_cases();
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_APPEND, 8'h00);
    send_item(OP_APPEND, 8'hFF);
    send_item(OP_APPEND, 8'h00);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_TEXT, 8'h00);
    // grow the pattern while a partial match is in flight
    send_item(OP_CLEAR, 8'hA5);
    send_item(OP_APPEND, 8'hAA);
    send_item(OP_APPEND, 8'hBB);
    send_item(OP_TEXT, 8'hAA);
    send_item(OP_APPEND, 8'hCC);
    send_item(OP_TEXT, 8'hBB);
    send_item(OP_TEXT, 8'hCC);
    // restart the text and match again from offset zero
    send_item(OP_TEXT, 8'hAA);
    send_item(OP_RESTART, 8'hFF);
    send_item(OP_TEXT, 8'hAA);
    send_item(OP_TEXT, 8'hBB);
    send_item(OP_TEXT, 8'hCC);
    hold_until_drained();
  endtask

  // Fill past capacity, then stream the stored pattern twice
  task automatic test_pattern_full();
    logic [7:0] sym [2];
    int         k;
    int         n;
    sym[0] = 8'($urandom);
    sym[1] = ~sym[0];
    send_item(OP_CLEAR, 8'($urandom));
    for (k = 0; k < PAT_MAX + 2; k++) send_item(OP_APPEND, sym[$urandom_range(1)]);
    n = pat_len;
    for (k = 0; k < n; k++) send_item(OP_TEXT, pat_mem[k]);
    for (k = 0; k < n; k++) send_item(OP_TEXT, pat_mem[k]);
  endtask

  // Random episodes: build a pattern, stream text drawn from its alphabet
  task automatic test_random_streams(int n_items);
    logic [7:0] alpha [4];
    int         alpha_n;
    int         stop;
    int         ep;
    int         plen;
    int         tlen;
    int         k;
    int         j;
    int         n;
    int         r;
    stop = items_sent + n_items;
    ep   = 0;
    while (items_sent < stop) begin
      no_idle = (ep >= 15 && ep < 27);
      if (ep % 19 == 7) hold_until_drained();
      // inject some noise
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) send_item(2'($urandom), 8'($urandom));
      end
      alpha_n = $urandom_range(1, 4);
      for (k = 0; k < 4; k++) alpha[k] = 8'($urandom);
      r = $urandom_range(99);
      if (r < 80) send_item(OP_CLEAR, 8'($urandom));
      else if (r < 90) send_item(OP_RESTART, 8'($urandom));
      r = $urandom_range(99);
      if (r < 70) plen = $urandom_range(1, 6);
      else if (r < 90) plen = $urandom_range(7, 20);
      else if (r < 97) plen = $urandom_range(21, PAT_MAX);
      else plen = $urandom_range(PAT_MAX + 1, PAT_MAX + 6);
      for (k = 0; k < plen; k++) send_item(OP_APPEND, alpha[$urandom_range(alpha_n - 1)]);
      tlen = $urandom_range(10, 50);
      for (k = 0; k < tlen; k++) begin
        r = $urandom_range(99);
        if (r < 3) begin
          send_item(OP_RESTART, 8'($urandom));
        end else if (r < 5) begin
          send_item(OP_APPEND, alpha[$urandom_range(alpha_n - 1)]);
        end else if (r < 8) begin
          send_item(OP_TEXT, 8'($urandom));
        end else if (r < 14) begin
          // plant a full copy of the pattern
          n = pat_len;
          for (j = 0; j < n; j++) send_item(OP_TEXT, pat_mem[j]);
        end else begin
          send_item(OP_TEXT, alpha[$urandom_range(alpha_n - 1)]);
        end
      end
      ep++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_pattern();
    test_directed_cases();
    test_pattern_full();
    test_random_streams(1600);
    hold_until_drained();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: kmp_stream_matcher_top.f
hdl/kmp_pkg.sv
hdl/kmp_datapath.sv
hdl/kmp_ctrl.sv
hdl/kmp_stream_matcher_top.sv
bench/tb_kmp_stream_matcher_top.sv
